### design/grtl_pkg.sv
`timescale 1ns / 1ps

package grtl_pkg;

	// Field widths fixed by the interface.
	localparam int unsigned CODE_W   = 16;
	localparam int unsigned OFFS_W   = 24;
	localparam int unsigned SLOT_W   = 6;
	localparam int unsigned DIM_W    = 8;
	localparam int unsigned COUNT_W  = 7;
	localparam int unsigned CFG_W    = 16;
	localparam int unsigned CFG_IX_W = 3;

	// Bytes per glyph is at most 31 * 255, which fits in 13 bits.
	localparam int unsigned PER_W  = 13;
	localparam int unsigned PROD_W = CODE_W + PER_W;
	localparam int unsigned SUM_W  = PROD_W + 1;

	// Operation codes.
	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	// Configuration register indexes.
	localparam logic [CFG_IX_W-1:0] REG_FONT_VALID    = 3'd0;
	localparam logic [CFG_IX_W-1:0] REG_ENTRY_COUNT   = 3'd1;
	localparam logic [CFG_IX_W-1:0] REG_GLYPH_WIDTH   = 3'd2;
	localparam logic [CFG_IX_W-1:0] REG_GLYPH_HEIGHT  = 3'd3;
	localparam logic [CFG_IX_W-1:0] REG_ROW_MAJOR     = 3'd4;
	localparam logic [CFG_IX_W-1:0] REG_INVALID_GLYPH = 3'd5;

	// Reset values of the glyph dimensions.
	localparam logic [DIM_W-1:0] GLYPH_WIDTH_RST  = 8'd8;
	localparam logic [DIM_W-1:0] GLYPH_HEIGHT_RST = 8'd16;

	// One range table entry as stored in memory.
	typedef struct packed {
		logic [CODE_W-1:0] first;
		logic [CODE_W-1:0] last;
		logic [OFFS_W-1:0] offset;
	} range_entry_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic wr_entry;
		logic init_lookup;
		logic init_subst;
		logic probe;
		logic check;
		logic mul;
		logic finish_hit;
		logic finish_miss;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic font_valid;
		logic empty;
		logic hit;
	} dp_status_t;

endpackage

### design/grtl_ram.sv
`timescale 1ns / 1ps

module grtl_ram #(
	parameter int unsigned WIDTH = 56,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### design/grtl_ctrl.sv
`timescale 1ns / 1ps

module grtl_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 op,
	input  grtl_pkg::dp_status_t status,
	output grtl_pkg::dp_cmd_t    cmd,
	output logic                 busy,
	output logic                 done
);

	import grtl_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PROBE,
		S_CHECK,
		S_MUL,
		S_HIT,
		S_MISS
	} state_t;

	state_t state_q;
	logic   subst_q;
	logic   done_q;
	logic   accept;

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign accept = start && !busy;

	// Command decode from the current state and datapath status.
	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.wr_entry    = accept && (op == OP_WRITE);
				cmd.init_lookup = accept && (op == OP_LOOKUP);
			end
			S_PROBE: begin
				cmd.probe      = !status.empty;
				cmd.init_subst = status.empty && !subst_q;
			end
			S_CHECK: cmd.check       = 1'b1;
			S_MUL:   cmd.mul         = 1'b1;
			S_HIT:   cmd.finish_hit  = 1'b1;
			S_MISS:  cmd.finish_miss = 1'b1;
			default: cmd = '0;
		endcase
	end

	// State, search phase and the result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			subst_q <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept && (op == OP_LOOKUP)) begin
						subst_q <= 1'b0;
						state_q <= status.font_valid ? S_PROBE : S_MISS;
					end
				end
				S_PROBE: begin
					if (!status.empty) begin
						state_q <= S_CHECK;
					end else if (!subst_q) begin
						// The code missed: search the substitute code next.
						subst_q <= 1'b1;
					end else begin
						state_q <= S_MISS;
					end
				end
				S_CHECK: begin
					state_q <= status.hit ? S_MUL : S_PROBE;
				end
				S_MUL: begin
					state_q <= S_HIT;
				end
				S_HIT, S_MISS: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

### design/grtl_dp.sv
`timescale 1ns / 1ps

module grtl_dp #(
	parameter int unsigned MAX_RANGES = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  grtl_pkg::dp_cmd_t              cmd,
	output grtl_pkg::dp_status_t           status,
	input  logic                           cfg_we,
	input  logic [grtl_pkg::CFG_IX_W-1:0]  cfg_index,
	input  logic [grtl_pkg::CFG_W-1:0]     cfg_data,
	input  logic [grtl_pkg::SLOT_W-1:0]    entry_index,
	input  logic [grtl_pkg::CODE_W-1:0]    range_first,
	input  logic [grtl_pkg::CODE_W-1:0]    range_last,
	input  logic [grtl_pkg::OFFS_W-1:0]    range_offset,
	input  logic [grtl_pkg::CODE_W-1:0]    glyph_code,
	output logic                           found,
	output logic                           used_invalid,
	output logic [grtl_pkg::OFFS_W-1:0]    byte_index,
	output logic                           index_overflow
);

	import grtl_pkg::*;

	localparam int unsigned AW = $clog2(MAX_RANGES);
	// Signed search bounds: low reaches MAX_RANGES, high reaches -1.
	localparam int unsigned SW = $clog2(MAX_RANGES + 1) + 1;

	// Configuration registers.
	logic              font_valid_q;
	logic [COUNT_W-1:0] entry_count_q;
	logic [DIM_W-1:0]  glyph_width_q;
	logic [DIM_W-1:0]  glyph_height_q;
	logic              row_major_q;
	logic [CODE_W-1:0] invalid_glyph_q;

	// Search and arithmetic registers.
	logic signed [SW-1:0] low_q;
	logic signed [SW-1:0] high_q;
	logic signed [SW-1:0] mid_q;
	logic [CODE_W-1:0]    code_q;
	logic                 subst_q;
	logic [PER_W-1:0]     per_q;
	logic [CODE_W-1:0]    delta_q;
	logic [OFFS_W-1:0]    offset_q;
	logic [PROD_W-1:0]    prod_q;

	logic signed [SW-1:0] count;
	logic signed [SW-1:0] mid;
	logic [31:0]          slot_ext;
	logic                 slot_ok;
	logic [4:0]           bytes_across;
	range_entry_t         wr_entry;
	range_entry_t         rd_entry;
	logic [SUM_W-1:0]     sum;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			font_valid_q    <= 1'b0;
			entry_count_q   <= '0;
			glyph_width_q   <= GLYPH_WIDTH_RST;
			glyph_height_q  <= GLYPH_HEIGHT_RST;
			row_major_q     <= 1'b0;
			invalid_glyph_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FONT_VALID:    font_valid_q    <= cfg_data[0];
				REG_ENTRY_COUNT:   entry_count_q   <= cfg_data[COUNT_W-1:0];
				REG_GLYPH_WIDTH:   glyph_width_q   <= cfg_data[DIM_W-1:0];
				REG_GLYPH_HEIGHT:  glyph_height_q  <= cfg_data[DIM_W-1:0];
				REG_ROW_MAJOR:     row_major_q     <= cfg_data[0];
				REG_INVALID_GLYPH: invalid_glyph_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Bytes per glyph, registered from the static configuration.
	always_comb begin
		if (row_major_q) begin
			bytes_across = glyph_width_q[DIM_W-1:3];
		end else begin
			bytes_across = glyph_height_q[DIM_W-1:3];
		end
		if (bytes_across == '0) begin
			bytes_across = 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (row_major_q) begin
			per_q <= PER_W'(bytes_across * glyph_height_q);
		end else begin
			per_q <= PER_W'(bytes_across * glyph_width_q);
		end
	end

	// Entry write slot; slots beyond the table are dropped.
	assign slot_ext = 32'(entry_index);
	assign slot_ok  = (slot_ext < MAX_RANGES);
	assign wr_entry = '{first: range_first, last: range_last, offset: range_offset};

	// Entry count saturated to the table depth.
	always_comb begin
		if (32'(entry_count_q) > MAX_RANGES) begin
			count = SW'(MAX_RANGES);
		end else begin
			count = SW'(entry_count_q);
		end
	end

	assign mid = low_q + ((high_q - low_q) >>> 1);

	grtl_ram #(
		.WIDTH($bits(range_entry_t)),
		.DEPTH(MAX_RANGES)
	) u_table (
		.clk  (clk),
		.we   (cmd.wr_entry && slot_ok),
		.waddr(slot_ext[AW-1:0]),
		.wdata(wr_entry),
		.re   (cmd.probe),
		.raddr(mid[AW-1:0]),
		.rdata(rd_entry)
	);

	assign status.font_valid = font_valid_q;
	assign status.empty      = (low_q > high_q);
	assign status.hit        = (code_q >= rd_entry.first) && (code_q <= rd_entry.last);

	// Binary search bounds and the probed entry's fields.
	always_ff @(posedge clk) begin
		if (cmd.init_lookup || cmd.init_subst) begin
			low_q  <= '0;
			high_q <= count - SW'(1);
			code_q <= cmd.init_subst ? invalid_glyph_q : glyph_code;
		end else if (cmd.check) begin
			if (status.hit) begin
				delta_q  <= code_q - rd_entry.first;
				offset_q <= rd_entry.offset;
			end else if (code_q < rd_entry.first) begin
				high_q <= mid_q - SW'(1);
			end else begin
				low_q <= mid_q + SW'(1);
			end
		end
		if (cmd.probe) begin
			mid_q <= mid;
		end
		if (cmd.init_lookup) begin
			subst_q <= 1'b0;
		end else if (cmd.init_subst) begin
			subst_q <= 1'b1;
		end
		if (cmd.mul) begin
			prod_q <= delta_q * per_q;
		end
	end

	assign sum = SUM_W'(offset_q) + SUM_W'(prod_q);

	// Result registers.
	always_ff @(posedge clk) begin
		if (cmd.finish_hit) begin
			found          <= 1'b1;
			used_invalid   <= subst_q;
			byte_index     <= sum[OFFS_W-1:0];
			index_overflow <= |sum[SUM_W-1:OFFS_W];
		end else if (cmd.finish_miss) begin
			found          <= 1'b0;
			used_invalid   <= 1'b0;
			byte_index     <= '0;
			index_overflow <= 1'b0;
		end
	end

endmodule

### design/glyph_range_table_locator_top.sv
`timescale 1ns / 1ps
// A range write leaves busy low; another start may follow at once.
// A lookup with an invalid font goes straight to a miss; otherwise each table probe
// is one memory read then one compare, up to floor(log2(entries in use))+1 probes per
// search; a hit then multiplies and loads the result, and a code that misses starts a
// second search for the substitute code. busy falls while done is high.
// done pulses one cycle, the receiver cannot stall; arst_n clears control and config.

module glyph_range_table_locator_top #(
	parameter int unsigned MAX_RANGES = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	output logic                          done,
	input  logic                          cfg_we,
	input  logic [grtl_pkg::CFG_IX_W-1:0] cfg_index,
	input  logic [grtl_pkg::CFG_W-1:0]    cfg_data,
	input  logic                          op,
	input  logic [grtl_pkg::SLOT_W-1:0]   entry_index,
	input  logic [grtl_pkg::CODE_W-1:0]   range_first,
	input  logic [grtl_pkg::CODE_W-1:0]   range_last,
	input  logic [grtl_pkg::OFFS_W-1:0]   range_offset,
	input  logic [grtl_pkg::CODE_W-1:0]   glyph_code,
	output logic                          found,
	output logic                          used_invalid,
	output logic [grtl_pkg::OFFS_W-1:0]   byte_index,
	output logic                          index_overflow
);

	import grtl_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	// Sequencer for writes and the two-pass search.
	grtl_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.op    (op),
		.status(status),
		.cmd   (cmd),
		.busy  (busy),
		.done  (done)
	);

	// Range table, search bounds and index arithmetic.
	grtl_dp #(
		.MAX_RANGES(MAX_RANGES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.entry_index   (entry_index),
		.range_first   (range_first),
		.range_last    (range_last),
		.range_offset  (range_offset),
		.glyph_code    (glyph_code),
		.found         (found),
		.used_invalid  (used_invalid),
		.byte_index    (byte_index),
		.index_overflow(index_overflow)
	);

endmodule

### sim/glyph_range_table_locator_top_test.sv
`timescale 1ns / 1ps

module glyph_range_table_locator_top_test;

	import grtl_pkg::*;

	localparam int TABLE_DEPTH  = 64;
	localparam int ITEM_TARGET  = 1400;
	localparam int CALM_ITEMS   = 200;
	localparam int DRAIN_CYCLES = 48;
	localparam int QUIET_LIMIT  = 2000;
	localparam int REPORT_MAX   = 10;

	// Port indexes past the last register; writes there must change nothing.
	localparam logic [CFG_IX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IX_W-1:0] REG_SPARE_HI = 3'd7;

	typedef enum {SHAPE_SORTED, SHAPE_REVERSED, SHAPE_SHUFFLED} table_shape_t;

	typedef struct packed {
		logic              op;
		logic [SLOT_W-1:0] slot;
		logic [CODE_W-1:0] first;
		logic [CODE_W-1:0] last;
		logic [OFFS_W-1:0] offset;
		logic [CODE_W-1:0] code;
	} glyph_item_t;

	typedef struct packed {
		logic              found;
		logic              used_invalid;
		logic [OFFS_W-1:0] byte_index;
		logic              index_overflow;
	} glyph_addr_t;

	typedef struct packed {
		logic [CODE_W-1:0] code;
		glyph_addr_t       addr;
	} pending_addr_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic                busy;
	logic                done;
	logic                cfg_we = 1'b0;
	logic [CFG_IX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]    cfg_data = '0;
	logic                op = OP_WRITE;
	logic [SLOT_W-1:0]   entry_index = '0;
	logic [CODE_W-1:0]   range_first = '0;
	logic [CODE_W-1:0]   range_last = '0;
	logic [OFFS_W-1:0]   range_offset = '0;
	logic [CODE_W-1:0]   glyph_code = '0;
	logic                found;
	logic                used_invalid;
	logic [OFFS_W-1:0]   byte_index;
	logic                index_overflow;

	glyph_range_table_locator_top dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.done           (done),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.op             (op),
		.entry_index    (entry_index),
		.range_first    (range_first),
		.range_last     (range_last),
		.range_offset   (range_offset),
		.glyph_code     (glyph_code),
		.found          (found),
		.used_invalid   (used_invalid),
		.byte_index     (byte_index),
		.index_overflow (index_overflow)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Shadow copy of the registers and the range table used for prediction.
	logic              font_on = 1'b0;
	logic [COUNT_W-1:0] entry_cnt = '0;
	logic [DIM_W-1:0]  glyph_w = GLYPH_WIDTH_RST;
	logic [DIM_W-1:0]  glyph_h = GLYPH_HEIGHT_RST;
	logic              row_mode = 1'b0;
	logic [CODE_W-1:0] subst_code = '0;
	logic [CODE_W-1:0] tbl_first [TABLE_DEPTH];
	logic [CODE_W-1:0] tbl_last [TABLE_DEPTH];
	logic [OFFS_W-1:0] tbl_offset [TABLE_DEPTH];

	// What the stimulus has put into the table so far, for picking codes.
	logic [CODE_W-1:0] plan_first [TABLE_DEPTH];
	logic [CODE_W-1:0] plan_last [TABLE_DEPTH];
	logic [OFFS_W-1:0] plan_offset [TABLE_DEPTH];
	bit                plan_written [TABLE_DEPTH];

	glyph_item_t   pending_q [$];
	pending_addr_t addr_q [$];
	glyph_item_t   next_item;

	int queued_items = 0;
	int accepted_items = 0;
	int idle_pct = 25;
	int gap_left = 0;
	int quiet_cycles = 0;
	int mismatch_count = 0;
	int lookups_checked = 0;
	int direct_hits = 0;
	int subst_hits = 0;
	int misses = 0;
	int overflows = 0;
	int writes_taken = 0;
	int phase_count = 0;

	// Binary search over the active entries; returns the full-width index on a hit.
	function automatic logic search_ranges(input logic [CODE_W-1:0] code,
		output longint unsigned at);
		int lo;
		int hi;
		int mid;
		longint unsigned per;
		longint unsigned blk;
		longint unsigned diff;
		at = 0;
		lo = 0;
		hi = ((entry_cnt > TABLE_DEPTH) ? TABLE_DEPTH : int'(entry_cnt)) - 1;
		if (row_mode) begin
			blk = 64'(glyph_w / 8);
			per = ((blk == 0) ? 64'd1 : blk) * 64'(glyph_h);
		end else begin
			blk = 64'(glyph_h / 8);
			per = ((blk == 0) ? 64'd1 : blk) * 64'(glyph_w);
		end
		while (lo <= hi) begin
			mid = lo + (hi - lo) / 2;
			if (code >= tbl_first[mid] && code <= tbl_last[mid]) begin
				diff = 64'(code - tbl_first[mid]);
				at = 64'(tbl_offset[mid]) + diff * per;
				return 1'b1;
			end
			if (code < tbl_first[mid])
				hi = mid - 1;
			else
				lo = mid + 1;
		end
		return 1'b0;
	endfunction

	// A lookup tries the code itself, then the substitute code if the font is loaded.
	function automatic glyph_addr_t locate_glyph(input logic [CODE_W-1:0] code);
		glyph_addr_t r;
		longint unsigned at;
		logic hit;
		logic subst;
		r = '0;
		at = 0;
		hit = 1'b0;
		subst = 1'b0;
		if (font_on) begin
			hit = search_ranges(code, at);
			if (!hit) begin
				hit = search_ranges(subst_code, at);
				subst = hit;
			end
		end
		if (hit) begin
			r.found = 1'b1;
			r.used_invalid = subst;
			r.byte_index = at[OFFS_W-1:0];
			r.index_overflow = (at > 64'hFFFFFF);
		end
		return r;
	endfunction

	// Driver: presents queued items on the command port, with random idle bursts.
	always @(posedge clk) begin
		if (arst_n && (!start || !busy)) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				start <= 1'b0;
			end else if (pending_q.size() != 0) begin
				next_item = pending_q.pop_front();
				start <= 1'b1;
				op <= next_item.op;
				entry_index <= next_item.slot;
				range_first <= next_item.first;
				range_last <= next_item.last;
				range_offset <= next_item.offset;
				glyph_code <= next_item.code;
				if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
					gap_left <= $urandom_range(1, 12);
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: checks each result strobe, then predicts for the transfer at this edge.
	always @(posedge clk) begin
		glyph_addr_t got;
		pending_addr_t want;
		if (arst_n) begin
			if (done) begin
				got = '{found, used_invalid, byte_index, index_overflow};
				if (addr_q.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_MAX)
						$display("%0t: result with no lookup pending: found %0b index %h",
							$realtime, got.found, got.byte_index);
				end else begin
					want = addr_q.pop_front();
					lookups_checked++;
					if (!want.addr.found) misses++;
					else if (want.addr.used_invalid) subst_hits++;
					else direct_hits++;
					if (want.addr.index_overflow) overflows++;
					if (got !== want.addr) begin
						mismatch_count++;
						if (mismatch_count <= REPORT_MAX)
							$display({"%0t: code %h expected found %0b subst %0b index %h ",
								"ovf %0b, got found %0b subst %0b index %h ovf %0b"},
								$realtime, want.code, want.addr.found,
								want.addr.used_invalid, want.addr.byte_index,
								want.addr.index_overflow, got.found, got.used_invalid,
								got.byte_index, got.index_overflow);
					end
				end
			end
			if (start && !busy) begin
				accepted_items++;
				if (op == OP_WRITE) begin
					// A 6-bit slot always falls inside a 64-entry table.
					tbl_first[entry_index] = range_first;
					tbl_last[entry_index] = range_last;
					tbl_offset[entry_index] = range_offset;
					writes_taken++;
				end else begin
					want.code = glyph_code;
					want.addr = locate_glyph(glyph_code);
					addr_q.insert(addr_q.size(), want);
				end
			end
		end
	end

	// Watchdog: ends the run when no transfer of any kind happens for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done || cfg_we)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no transfer for %0d cycles, %0d lookups outstanding",
					$realtime, QUIET_LIMIT, addr_q.size());
				$display("Mismatches found");
				$finish;
			end
		end
	end

	task automatic push_write(input int slot, input logic [CODE_W-1:0] first,
		input logic [CODE_W-1:0] last, input logic [OFFS_W-1:0] offset);
		glyph_item_t it;
		it.op = OP_WRITE;
		it.slot = SLOT_W'(slot);
		it.first = first;
		it.last = last;
		it.offset = offset;
		it.code = CODE_W'($urandom);
		plan_first[slot] = first;
		plan_last[slot] = last;
		plan_offset[slot] = offset;
		plan_written[slot] = 1'b1;
		pending_q.insert(pending_q.size(), it);
		queued_items++;
	endtask

	task automatic push_lookup(input logic [CODE_W-1:0] code);
		glyph_item_t it;
		it.op = OP_LOOKUP;
		it.slot = SLOT_W'($urandom);
		it.first = CODE_W'($urandom);
		it.last = CODE_W'($urandom);
		it.offset = OFFS_W'($urandom);
		it.code = code;
		pending_q.insert(pending_q.size(), it);
		queued_items++;
	endtask

	task automatic reg_write(input logic [CFG_IX_W-1:0] idx, input logic [CFG_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			REG_FONT_VALID:    font_on = data[0];
			REG_ENTRY_COUNT:   entry_cnt = data[COUNT_W-1:0];
			REG_GLYPH_WIDTH:   glyph_w = data[DIM_W-1:0];
			REG_GLYPH_HEIGHT:  glyph_h = data[DIM_W-1:0];
			REG_ROW_MAJOR:     row_mode = data[0];
			REG_INVALID_GLYPH: subst_code = data[CODE_W-1:0];
			default: ;
		endcase
	endtask

	// Sometimes sets the bits above a register's width; they must be dropped.
	function automatic logic [CFG_W-1:0] with_junk(input logic [CFG_W-1:0] v, input int bits);
		logic [31:0] keep;
		logic [31:0] junk;
		keep = (32'd1 << bits) - 32'd1;
		junk = $urandom;
		if ($urandom_range(0, 3) == 0)
			return CFG_W'((v & keep) | (junk & ~keep));
		return CFG_W'(v & keep);
	endfunction

	task automatic configure(input logic fv, input int cnt, input logic [DIM_W-1:0] w,
		input logic [DIM_W-1:0] h, input logic rm, input logic [CODE_W-1:0] ig);
		reg_write(REG_FONT_VALID, with_junk(CFG_W'(fv), 1));
		reg_write(REG_ENTRY_COUNT, with_junk(CFG_W'(cnt), COUNT_W));
		reg_write(REG_GLYPH_WIDTH, with_junk(CFG_W'(w), DIM_W));
		reg_write(REG_GLYPH_HEIGHT, with_junk(CFG_W'(h), DIM_W));
		reg_write(REG_ROW_MAJOR, with_junk(CFG_W'(rm), 1));
		reg_write(REG_INVALID_GLYPH, ig);
		@(posedge clk);
		cfg_we <= 1'b0;
		phase_count++;
	endtask

	// Waits until every item has been taken and answered, then lets the block finish.
	task automatic settle;
		while (accepted_items != queued_items || addr_q.size() != 0 || busy)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic int written_prefix;
		int n;
		n = 0;
		while (n < TABLE_DEPTH && plan_written[n])
			n++;
		return n;
	endfunction

	// Builds n entries ordered by first code, then damages some for the odd shapes.
	task automatic plan_table(input int n, input table_shape_t shape);
		int cur;
		int span;
		int i;
		int j;
		cur = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4000);
		for (i = 0; i < n; i++) begin
			span = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1500) : $urandom_range(0, 24);
			if (cur > 65535) cur = 65535;
			plan_first[i] = CODE_W'(cur);
			plan_last[i] = (cur + span > 65535) ? 16'hFFFF : CODE_W'(cur + span);
			if (i == n - 1 && $urandom_range(0, 5) == 0) plan_last[i] = 16'hFFFF;
			if ($urandom_range(0, 3) == 0)
				plan_offset[i] = 24'hFFFFFF - OFFS_W'($urandom_range(0, 5000));
			else
				plan_offset[i] = OFFS_W'($urandom);
			plan_written[i] = 1'b1;
			cur = cur + span + 1 + (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 60));
		end
		if (shape == SHAPE_REVERSED) begin
			repeat ($urandom_range(1, 3)) begin
				j = $urandom_range(0, n - 1);
				if (plan_first[j] != 0)
					plan_last[j] = plan_first[j] - CODE_W'($urandom_range(1, plan_first[j]));
			end
		end else if (shape == SHAPE_SHUFFLED) begin
			repeat ($urandom_range(1, 4)) begin
				j = $urandom_range(0, n - 1);
				plan_first[j] = CODE_W'($urandom);
				plan_last[j] = (plan_first[j] > 16'hFFC0) ? 16'hFFFF : plan_first[j] + 16'd40;
			end
		end
	endtask

	// Mostly codes inside or at the edges of active entries, some elsewhere.
	function automatic logic [CODE_W-1:0] pick_code(input int used);
		int j;
		int r;
		r = $urandom_range(0, 18);
		if (used == 0 || r == 18) return CODE_W'($urandom);
		j = $urandom_range(0, used - 1);
		if (r < 12) begin
			if (plan_first[j] <= plan_last[j])
				return plan_first[j] + CODE_W'($urandom_range(0, plan_last[j] - plan_first[j]));
			return plan_first[j];
		end
		if (r == 12) return plan_first[j];
		if (r == 13) return plan_last[j];
		if (r <= 15) return plan_last[j] + 16'd1;
		if (r == 16) return subst_code;
		return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
	endfunction

	function automatic logic [DIM_W-1:0] pick_dim;
		case ($urandom_range(0, 5))
			0: return 8'd0;
			1: return 8'd255;
			2: return DIM_W'($urandom_range(1, 7));
			default: return DIM_W'($urandom);
		endcase
	endfunction

	initial begin : stimulus
		int n;
		int used;
		int cnt;
		int pre;
		int r;
		logic fv;
		logic rm;
		logic [DIM_W-1:0] w;
		logic [DIM_W-1:0] h;
		logic [CODE_W-1:0] ig;
		table_shape_t shape;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Out of reset the font is not loaded, so the lookup must miss.
		push_lookup(16'h0041);
		settle();

		// Writes past the last register, then a loaded font with an empty table.
		reg_write(REG_SPARE_LO, CFG_W'($urandom));
		reg_write(REG_SPARE_HI, CFG_W'($urandom));
		configure(1'b1, 0, 8'd8, 8'd16, 1'b0, 16'h0000);
		push_lookup(16'hFFFF);
		settle();

		// Small table: a single-code entry, a reversed range, an entry at the
		// top offset and one running to the last code; slot 63 written too.
		push_write(0, 16'h0000, 16'h0000, 24'h000000);
		push_write(1, 16'd10, 16'd5, OFFS_W'($urandom));
		push_write(2, 16'd100, 16'd200, 24'hFFFFFF);
		push_write(3, 16'd300, 16'hFFFF, 24'd1234);
		push_write(63, 16'hFFFF, 16'h0000, OFFS_W'($urandom));
		settle();

		// Widest glyphs in rows: hits, overflow, and substitution to the last code.
		configure(1'b1, 4, 8'd255, 8'd255, 1'b1, 16'hFFFF);
		push_lookup(16'd0);
		push_lookup(16'd7);
		push_lookup(16'd5);
		push_lookup(16'd100);
		push_lookup(16'd101);
		push_lookup(16'hFFFF);
		push_lookup(16'd250);
		settle();

		// Zero-size glyphs in columns; the substitute code misses as well.
		configure(1'b1, 4, 8'd0, 8'd0, 1'b0, 16'd8);
		push_lookup(16'd250);
		push_lookup(16'd150);
		settle();

		// Zero width in rows; a miss falls back to code 0.
		configure(1'b1, 4, 8'd0, 8'd255, 1'b1, 16'h0000);
		push_lookup(16'd301);
		push_lookup(16'd250);
		settle();

		// Font not loaded: even a code inside a range misses.
		configure(1'b0, 4, 8'd8, 8'd16, 1'b0, 16'h0000);
		push_lookup(16'd100);
		settle();

		// Random phases: a fresh table, new settings, then a stream of lookups.
		while (queued_items < ITEM_TARGET) begin
			if (queued_items > ITEM_TARGET - CALM_ITEMS) begin
				idle_pct = 0;
			end else begin
				r = $urandom_range(0, 3);
				idle_pct = (r == 0) ? 0 : ((r == 1) ? 10 : 35);
			end
			r = $urandom_range(0, 9);
			if (r == 0) n = TABLE_DEPTH;
			else if (r == 1) n = $urandom_range(9, 32);
			else n = $urandom_range(1, 8);
			r = $urandom_range(0, 9);
			shape = (r < 7) ? SHAPE_SORTED : ((r < 9) ? SHAPE_REVERSED : SHAPE_SHUFFLED);
			plan_table(n, shape);

			pre = written_prefix();
			cnt = n;
			r = $urandom_range(0, 9);
			if (r == 0) cnt = $urandom_range(0, pre);
			else if (r == 1 && pre == TABLE_DEPTH) cnt = $urandom_range(TABLE_DEPTH + 1, 127);
			used = (cnt > TABLE_DEPTH) ? TABLE_DEPTH : cnt;
			fv = ($urandom_range(0, 7) != 0);
			rm = 1'($urandom_range(0, 1));
			w = pick_dim();
			h = pick_dim();
			r = $urandom_range(0, 7);
			if (r < 4) ig = pick_code(used);
			else if (r < 6) ig = CODE_W'($urandom);
			else if (r == 6) ig = 16'h0000;
			else ig = 16'hFFFF;
			configure(fv, cnt, w, h, rm, ig);

			for (int i = 0; i < n; i++)
				push_write(i, plan_first[i], plan_last[i], plan_offset[i]);
			repeat ($urandom_range(15, 45)) begin
				if ($urandom_range(0, 19) == 0)
					push_write($urandom_range(0, TABLE_DEPTH - 1), CODE_W'($urandom),
						CODE_W'($urandom), OFFS_W'($urandom));
				else
					push_lookup(pick_code(used));
			end
			settle();
		end

		$display("Checked %0d lookups: %0d direct hits, %0d substitutions, %0d misses, %0d overflows",
			lookups_checked, direct_hits, subst_hits, misses, overflows);
		$display("Range writes taken: %0d over %0d register settings", writes_taken, phase_count);
		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("%0d mismatching results", mismatch_count);
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
